[rtl/core/tasol_pkg.sv]
// ----------------------------------------------------------------------------
// tasol_pkg
// Shared constants for the three-axis second-order low-pass unit: axis count
// and the index codes of the coefficient registers.
// ----------------------------------------------------------------------------
package tasol_pkg;

   localparam int NUM_AXES = 3;
   localparam int CSR_ADDR_WIDTH = 2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_INPUT_GAIN      = 2'd0,
      CSR_FIRST_FEEDBACK  = 2'd1,
      CSR_SECOND_FEEDBACK = 2'd2
   } csr_index_type;

endpackage

[rtl/core/three_axis_second_order_lowpass_unit.sv]
// ----------------------------------------------------------------------------
// three_axis_second_order_lowpass_unit
// Recursive second-order low-pass, y = b0*x + a1*y1 - a2*y2, on three axes.
//
// Usage:
//  - req_ channel: one transfer carries one signed sample per axis.
//  - rsp_ channel: one transfer per request with the rounded, saturated
//    filtered value per axis; rsp_tuser flags saturation on any axis.
//  - csr_ port: write b0 (index 0), a1 (index 1), a2 (index 2) as unsigned
//    Q1.COEFF_FRAC_BITS values while the unit is idle.
//  - Path: a request goes through the input register, then the result
//    register, before rsp_tvalid rises. Throughput: one sample per cycle
//    while rsp_tready keeps the result register free; the filter update for
//    a sample is combinational between the input register and the result
//    register, per axis one pass of three multipliers, an adder and the
//    rounding logic.
//  - Reset: filter history cleared, b0 = 1.0, a1 = a2 = 0.
//  - When rsp_tready is low the result is held, one more request is taken
//    into the input register, and the history advances only as results
//    move into the result register.
// ----------------------------------------------------------------------------
module three_axis_second_order_lowpass_unit #(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int COEFF_FRAC_BITS = 16,
   parameter int STATE_FRAC_BITS = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sample_x, sample_y, sample_z, zero padding
   input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // filtered_x, filtered_y, filtered_z, zero padding
   output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // clipped
   output logic [0:0]                               rsp_tuser,
   input  logic                                     csr_wen,
   input  logic [tasol_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [COEFF_FRAC_BITS:0]                 csr_wdata
);

   localparam int AXES      = tasol_pkg::NUM_AXES;
   localparam int SW        = SAMPLE_WIDTH;
   localparam int CW        = COEFF_FRAC_BITS + 1;
   localparam int STW       = SAMPLE_WIDTH + STATE_FRAC_BITS;
   localparam int ACC_W     = STW + CW + 3;
   localparam int RS_W      = ACC_W - COEFF_FRAC_BITS;
   localparam int DATA_W    = ((3*SAMPLE_WIDTH+7)/8)*8;
   localparam int PAD_W     = DATA_W - AXES*SAMPLE_WIDTH;

   logic [CW-1:0] gain_ff, gain_in;
   logic [CW-1:0] fb1_ff, fb1_in;
   logic [CW-1:0] fb2_ff, fb2_in;

   logic                 in_valid_ff, in_valid_in;
   logic signed [SW-1:0] in_sample_ff [AXES];
   logic signed [SW-1:0] in_sample_in [AXES];

   logic signed [STW-1:0] last_ff  [AXES];
   logic signed [STW-1:0] last_in  [AXES];
   logic signed [STW-1:0] prior_ff [AXES];
   logic signed [STW-1:0] prior_in [AXES];

   logic                 out_valid_ff, out_valid_in;
   logic signed [SW-1:0] out_data_ff [AXES];
   logic signed [SW-1:0] out_data_in [AXES];
   logic                 out_clip_ff, out_clip_in;

   logic signed [STW-1:0] new_state [AXES];
   logic signed [SW-1:0]  new_out   [AXES];
   logic [AXES-1:0]       axis_hit;

   logic req_fire;
   logic advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // coefficient registers
   always_comb begin
      gain_in = gain_ff;
      fb1_in  = fb1_ff;
      fb2_in  = fb2_ff;
      if (csr_wen) begin
         case (csr_addr)
            tasol_pkg::CSR_INPUT_GAIN:      gain_in = csr_wdata;
            tasol_pkg::CSR_FIRST_FEEDBACK:  fb1_in  = csr_wdata;
            tasol_pkg::CSR_SECOND_FEEDBACK: fb2_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= CW'(1) << COEFF_FRAC_BITS;
         fb1_ff  <= '0;
         fb2_ff  <= '0;
      end else begin
         gain_ff <= gain_in;
         fb1_ff  <= fb1_in;
         fb2_ff  <= fb2_in;
      end
   end

   // per-axis filter datapath
   for (genvar g = 0; g < AXES; g++) begin : g_axis
      logic signed [SW+CW:0]    prod_x;
      logic signed [STW+CW:0]   prod_1;
      logic signed [STW+CW:0]   prod_2;
      logic signed [ACC_W-1:0]  acc;
      logic signed [ACC_W-1:0]  acc_rnd;
      logic signed [RS_W-1:0]   sum_r;
      logic [RS_W-STW:0]        sum_hi;
      logic                     state_pos;
      logic                     state_neg;
      logic                     out_hit;

      localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (COEFF_FRAC_BITS-1);
      localparam logic signed [STW-1:0]   STATE_MAX = {1'b0, {(STW-1){1'b1}}};
      localparam logic signed [STW-1:0]   STATE_MIN = {1'b1, {(STW-1){1'b0}}};

      assign prod_x  = in_sample_ff[g] * $signed({1'b0, gain_ff});
      assign prod_1  = last_ff[g]      * $signed({1'b0, fb1_ff});
      assign prod_2  = prior_ff[g]     * $signed({1'b0, fb2_ff});
      assign acc     = (ACC_W'(prod_x) <<< STATE_FRAC_BITS) + ACC_W'(prod_1)
                       - ACC_W'(prod_2);
      assign acc_rnd = acc + ACC_HALF;
      assign sum_r   = $signed(acc_rnd[ACC_W-1:COEFF_FRAC_BITS]);
      assign sum_hi  = sum_r[RS_W-1:STW-1];

      assign state_pos = !sum_r[RS_W-1] && (|sum_hi);
      assign state_neg = sum_r[RS_W-1] && !(&sum_hi);

      always_comb begin
         if (state_pos) begin
            new_state[g] = STATE_MAX;
         end else if (state_neg) begin
            new_state[g] = STATE_MIN;
         end else begin
            new_state[g] = sum_r[STW-1:0];
         end
      end

      if (STATE_FRAC_BITS > 0) begin : g_round
         localparam logic signed [STW:0] OUT_HALF = (STW+1)'(1) << (STATE_FRAC_BITS-1);
         logic signed [STW:0]  ext_rnd;
         logic signed [SW:0]   out_r;

         assign ext_rnd = {new_state[g][STW-1], new_state[g]} + OUT_HALF;
         assign out_r   = $signed(ext_rnd[STW:STATE_FRAC_BITS]);
         assign out_hit = out_r[SW] != out_r[SW-1];

         always_comb begin
            if (!out_hit) begin
               new_out[g] = out_r[SW-1:0];
            end else if (out_r[SW]) begin
               new_out[g] = {1'b1, {(SW-1){1'b0}}};
            end else begin
               new_out[g] = {1'b0, {(SW-1){1'b1}}};
            end
         end
      end else begin : g_direct
         assign out_hit    = 1'b0;
         assign new_out[g] = new_state[g][SW-1:0];
      end

      assign axis_hit[g] = state_pos || state_neg || out_hit;
   end

   // pipeline and history next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_clip_in  = out_clip_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_clip_in  = |axis_hit;
      end
      for (int i = 0; i < AXES; i++) begin
         in_sample_in[i] = req_fire ? $signed(req_tdata[i*SW +: SW]) : in_sample_ff[i];
         last_in[i]      = advance ? new_state[i] : last_ff[i];
         prior_in[i]     = advance ? last_ff[i]   : prior_ff[i];
         out_data_in[i]  = advance ? new_out[i]   : out_data_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            last_ff[i]  <= '0;
            prior_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < AXES; i++) begin
            last_ff[i]  <= last_in[i];
            prior_ff[i] <= prior_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_clip_ff <= out_clip_in;
      for (int i = 0; i < AXES; i++) begin
         in_sample_ff[i] <= in_sample_in[i];
         out_data_ff[i]  <= out_data_in[i];
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_clip_ff;

   for (genvar g = 0; g < AXES; g++) begin : g_pack
      assign rsp_tdata[g*SW +: SW] = out_data_ff[g];
   end

   if (PAD_W > 0) begin : g_pad
      assign rsp_tdata[DATA_W-1:AXES*SW] = '0;
   end

   // checks
   a_advance_fills_output: assert property (@(posedge clock)
      !reset && advance |=> rsp_tvalid)
      else $error("result register not loaded after advance");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff && !rsp_tready)
      else $error("request side stalled without a full pipeline");

   a_history_shift: assert property (@(posedge clock)
      !reset && advance |=> prior_ff[0] == $past(last_ff[0]))
      else $error("history did not shift on advance");

   a_history_hold: assert property (@(posedge clock)
      !reset && !advance |=> $stable(last_ff[0]) && $stable(prior_ff[0]))
      else $error("history changed without a sample");

endmodule

[sim/three_axis_second_order_lowpass_unit_tb.sv]
// ----------------------------------------------------------------------------
// three_axis_second_order_lowpass_unit_tb
// Self-checking bench for the three-axis second-order low-pass unit. A
// queue-fed driver offers samples in random bursts, a fixed-point filter
// model predicts each result on request transfer, and a monitor compares
// every result transfer while stalling the result channel on its own pattern.
// Coefficients change between drained phases, from pass-through and unstable
// settings to random and extreme ones.
// ----------------------------------------------------------------------------
module three_axis_second_order_lowpass_unit_tb;

   localparam logic [tasol_pkg::CSR_ADDR_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam longint STATE_MAX = 64'sd8388607;
   localparam longint STATE_MIN = -64'sd8388608;
   localparam longint SAMPLE_MAX = 64'sd32767;
   localparam longint SAMPLE_MIN = -64'sd32768;
   localparam int PHASE_ITEMS = 210;

   typedef struct packed {
      logic             clipped;
      logic [2:0][15:0] axis;
   } filter_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_MOSTLY_OPEN,
      RX_MOSTLY_SHUT
   } rx_mode_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [47:0]                           req_tdata = '0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [47:0]                           rsp_tdata;
   logic [0:0]                            rsp_tuser;
   logic                                  csr_wen = 1'b0;
   logic [tasol_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr = '0;
   logic [16:0]                           csr_wdata = '0;

   logic [16:0]        gain_b0 = 17'h10000;
   logic [16:0]        feedback_a1 = '0;
   logic [16:0]        feedback_a2 = '0;
   logic signed [23:0] last_out [3] = '{default: '0};
   logic signed [23:0] prior_out [3] = '{default: '0};

   logic [47:0]       sample_q [$];
   filter_result_type filtered_q [$];
   int                error_count = 0;
   logic              hold_request = 1'b0;
   string             axis_name [3] = '{"filtered_x", "filtered_y", "filtered_z"};

   three_axis_second_order_lowpass_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void filter_sample(input logic [47:0] samples);
      filter_result_type res;
      longint x, y1, y2, b0, a1, a2, acc, state_next, out_val;
      res = '0;
      b0 = gain_b0;
      a1 = feedback_a1;
      a2 = feedback_a2;
      for (int i = 0; i < 3; i++) begin
         x = $signed(samples[16*i +: 16]);
         y1 = last_out[i];
         y2 = prior_out[i];
         acc = ((x * b0) <<< 8) + y1 * a1 - y2 * a2;
         state_next = (acc + 64'sd32768) >>> 16;
         if (state_next > STATE_MAX) begin
            state_next = STATE_MAX;
            res.clipped = 1'b1;
         end else if (state_next < STATE_MIN) begin
            state_next = STATE_MIN;
            res.clipped = 1'b1;
         end
         out_val = (state_next + 64'sd128) >>> 8;
         if (out_val > SAMPLE_MAX) begin
            out_val = SAMPLE_MAX;
            res.clipped = 1'b1;
         end else if (out_val < SAMPLE_MIN) begin
            out_val = SAMPLE_MIN;
            res.clipped = 1'b1;
         end
         prior_out[i] = last_out[i];
         last_out[i] = state_next[23:0];
         res.axis[i] = out_val[15:0];
      end
      filtered_q.push_back(res);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic queue_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
      sample_q.push_back({z, y, x});
   endtask

   task automatic write_csr(input logic [tasol_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [16:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (addr)
         tasol_pkg::CSR_INPUT_GAIN:      gain_b0 = value;
         tasol_pkg::CSR_FIRST_FEEDBACK:  feedback_a1 = value;
         tasol_pkg::CSR_SECOND_FEEDBACK: feedback_a2 = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_tvalid || filtered_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // driver: bursts of transfers with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) filter_sample(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || sample_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= sample_q.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(0, 7);
                  gap_left = $urandom_range(0, 5);
               end
            end
         end
      end
   end

   // monitor: check each result transfer, stall on its own pattern
   rx_mode_type rx_mode = RX_OPEN;
   int          mode_left = 0;
   int          hold_left = 0;

   always @(posedge clock) begin
      filter_result_type head;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               $error("result transfer with no expected result: tdata %h tuser %b",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               head = filtered_q.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (rsp_tdata[16*i +: 16] !== head.axis[i]) begin
                     $error("%s: expected %0d, actual %0d", axis_name[i],
                            $signed(head.axis[i]), $signed(rsp_tdata[16*i +: 16]));
                     error_count++;
                  end
               end
               if (rsp_tuser[0] !== head.clipped) begin
                  $error("clipped: expected %0b, actual %0b", head.clipped, rsp_tuser[0]);
                  error_count++;
               end
            end
         end
         if (hold_request) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:        rsp_tready <= 1'b1;
               RX_COIN:        rsp_tready <= 1'($urandom_range(0, 1));
               RX_MOSTLY_OPEN: rsp_tready <= ($urandom_range(0, 7) != 0);
               default:        rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #8_000_000;
      $display("three_axis_second_order_lowpass_unit_tb failed");
      $finish;
   end

   initial begin
      int          count;
      int          run;
      logic [15:0] base_x, base_y, base_z;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // pass-through after reset
      queue_sample(16'h7fff, 16'h8000, 16'h0000);
      queue_sample(16'h8000, 16'h7fff, 16'hffff);
      queue_sample(16'h0001, 16'hffff, 16'h0000);
      queue_sample(16'h5555, 16'haaaa, 16'h7fff);
      queue_sample(16'hffff, 16'h0001, 16'h8000);
      queue_sample(16'h0000, 16'h0000, 16'h0000);
      wait_for_drain();

      // write to an unmapped index must leave the filter unchanged
      write_csr(CSR_UNUSED, 17'h1ffff);
      queue_sample(16'h1234, 16'h8000, 16'h7fff);
      wait_for_drain();

      // unstable feedback drives the history into saturation
      write_csr(tasol_pkg::CSR_INPUT_GAIN, 17'h10000);
      write_csr(tasol_pkg::CSR_FIRST_FEEDBACK, 17'h1ffff);
      write_csr(tasol_pkg::CSR_SECOND_FEEDBACK, 17'h00000);
      repeat (6) queue_sample(16'h7fff, 16'h8000, 16'h0100);
      wait_for_drain();

      // gain beyond 1.0 and full second feedback
      write_csr(tasol_pkg::CSR_INPUT_GAIN, 17'h1ffff);
      write_csr(tasol_pkg::CSR_FIRST_FEEDBACK, 17'h00000);
      write_csr(tasol_pkg::CSR_SECOND_FEEDBACK, 17'h10000);
      repeat (4) queue_sample(16'h8000, 16'h7fff, 16'h0001);
      repeat (3) queue_sample(16'h0000, 16'h0000, 16'h0000);
      wait_for_drain();

      for (int k = 0; k < 8; k++) begin
         case (k % 5)
            0: begin
               write_csr(tasol_pkg::CSR_INPUT_GAIN, 17'($urandom_range(1, 4000)));
               write_csr(tasol_pkg::CSR_FIRST_FEEDBACK, 17'($urandom_range(90000, 131071)));
               write_csr(tasol_pkg::CSR_SECOND_FEEDBACK, 17'($urandom_range(30000, 65536)));
            end
            1: begin
               write_csr(tasol_pkg::CSR_INPUT_GAIN, 17'($urandom()));
               write_csr(tasol_pkg::CSR_FIRST_FEEDBACK, 17'($urandom()));
               write_csr(tasol_pkg::CSR_SECOND_FEEDBACK, 17'($urandom()));
            end
            2: begin
               write_csr(tasol_pkg::CSR_INPUT_GAIN,
                         ($urandom_range(0, 1) != 0) ? 17'h1ffff : 17'h00000);
               write_csr(tasol_pkg::CSR_FIRST_FEEDBACK,
                         ($urandom_range(0, 1) != 0) ? 17'h1ffff : 17'h00000);
               write_csr(tasol_pkg::CSR_SECOND_FEEDBACK,
                         ($urandom_range(0, 1) != 0) ? 17'h10000 : 17'h00000);
            end
            3: begin
               write_csr(tasol_pkg::CSR_INPUT_GAIN, 17'h10000);
               write_csr(tasol_pkg::CSR_FIRST_FEEDBACK, 17'h00000);
               write_csr(tasol_pkg::CSR_SECOND_FEEDBACK, 17'h00000);
            end
            default: begin
               write_csr(tasol_pkg::CSR_INPUT_GAIN, 17'($urandom_range(0, 65536)));
               write_csr(tasol_pkg::CSR_FIRST_FEEDBACK, 17'($urandom_range(0, 131071)));
               write_csr(tasol_pkg::CSR_SECOND_FEEDBACK, 17'($urandom_range(0, 65536)));
            end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            run = $urandom_range(1, 40);
            base_x = pick_sample();
            base_y = pick_sample();
            base_z = pick_sample();
            for (int j = 0; j < run && count < PHASE_ITEMS; j++) begin
               if ($urandom_range(0, 3) == 0)
                  queue_sample(pick_sample(), pick_sample(), pick_sample());
               else
                  queue_sample(base_x, base_y, base_z);
               count++;
            end
         end
         if (k == 1 || k == 5) begin
            @(negedge clock);
            hold_request = 1'b1;
         end
         wait_for_drain();
      end

      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("three_axis_second_order_lowpass_unit_tb passed");
      else
         $display("three_axis_second_order_lowpass_unit_tb failed");
      $finish;
   end

endmodule
